@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the calendar date converter. Each check is
// clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date converter package
// Constants, tables, stage-to-stage word types and small helpers shared by
// the pipeline modules.
// ----------------------------------------------------------------------------
package scd_pkg;

  // Field widths.
  localparam int SECS_W = 41;
  localparam int YEAR_W = 16;

  // Interval lengths in seconds.
  localparam logic [26:0] BLOCK_SECONDS      = 27'd126230400;
  localparam logic [24:0] LEAP_YEAR_SECONDS  = 25'd31622400;
  localparam logic [24:0] PLAIN_YEAR_SECONDS = 25'd31536000;
  localparam logic [16:0] DAY_SECONDS        = 17'd86400;
  localparam logic [11:0] HOUR_SECONDS       = 12'd3600;
  localparam logic [5:0]  MINUTE_SECONDS     = 6'd60;
  localparam int          WEEK_CYCLE_YEARS   = 28;

  // Stage counts of the three pipeline sections.
  localparam int BLK_STAGES = 8;
  localparam int DAY_STAGES = 6;
  localparam int HMS_STAGES = 6;

  // First day of each month within the year; row 1 is the leap year.
  localparam logic [8:0] MONTH_START [2][12] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

  // Weekday of the first day of each year of the 28-year cycle, modulo 7.
  localparam logic [2:0] WEEK_OFFSET_MOD7 [WEEK_CYCLE_YEARS] = '{
    3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5,
    3'd6, 3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1, 3'd2, 3'd3,
    3'd4, 3'd6, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6
  };

  // Word between the block divider and the day divider.
  typedef struct packed {
    logic [13:0] blocks_lo;    // four-year block count, low bits
    logic [2:0]  blocks_mod7;  // block count modulo 7
    logic [26:0] rest;         // seconds within the block
  } blk_t;

  // Word between the day divider and the clock splitter.
  typedef struct packed {
    logic [15:0] year;
    logic [4:0]  cycle_year;   // year modulo 28
    logic        leap;
    logic [8:0]  yday;
    logic [2:0]  yday_mod7;
    logic [16:0] sod;          // seconds within the day
  } day_t;

  // Residue update for one radix-4 quotient digit: (4*m + d) mod 7.
  function automatic logic [2:0] mod7_step(input logic [2:0] m, input logic [1:0] d);
    logic [4:0] t;
    t = {m, 2'b00} + {3'b000, d};
    if (t >= 5'd21) begin
      return 3'(t - 5'd21);
    end else if (t >= 5'd14) begin
      return 3'(t - 5'd14);
    end else if (t >= 5'd7) begin
      return 3'(t - 5'd7);
    end
    return 3'(t);
  endfunction

  // Sum of two residues modulo 7.
  function automatic logic [2:0] mod7_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= 4'd7) begin
      return 3'(t - 4'd7);
    end
    return 3'(t);
  endfunction

endpackage

@@ rtl/core/scd_block_div.sv @@
// ----------------------------------------------------------------------------
// Four-year block divider
// Radix-4 restoring division of the second count by the block length, two
// quotient bits per stage, with the quotient residue modulo 7 kept alongside.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_block_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [scd_pkg::SECS_W-1:0] in_seconds,
  output logic                      out_valid,
  input  logic                      out_ready,
  output scd_pkg::blk_t             out_blk
);

  localparam int N = scd_pkg::BLK_STAGES;

  logic [N-1:0] v_r;
  logic [N-1:0] v_in;
  logic [N:0]   en;
  logic [42:0]  r_in   [N];
  logic [13:0]  q_in   [N];
  logic [2:0]   m7_in  [N];
  logic [40:0]  rem_nxt [N];
  logic [13:0]  q_nxt  [N];
  logic [2:0]   m7_nxt [N];
  logic [40:0]  rem_r  [N];
  logic [13:0]  q_r    [N];
  logic [2:0]   m7_r   [N];

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  // Stage inputs.
  always_comb begin
    v_in[0]  = in_valid;
    r_in[0]  = {2'b00, in_seconds};
    q_in[0]  = '0;
    m7_in[0] = '0;
    for (int s = 1; s < N; s++) begin
      v_in[s]  = v_r[s-1];
      r_in[s]  = {2'b00, rem_r[s-1]};
      q_in[s]  = q_r[s-1];
      m7_in[s] = m7_r[s-1];
    end
  end

  // One radix-4 digit per stage: compare against 1x, 2x and 3x the shifted
  // divisor in parallel and keep the largest that fits.
  always_comb begin
    logic [42:0] c1, c2, c3, diff;
    logic [1:0]  dig;
    for (int s = 0; s < N; s++) begin
      c1 = 43'(scd_pkg::BLOCK_SECONDS) << (2 * (N - 1 - s));
      c2 = c1 << 1;
      c3 = c1 + c2;
      if (r_in[s] >= c3) begin
        dig  = 2'd3;
        diff = r_in[s] - c3;
      end else if (r_in[s] >= c2) begin
        dig  = 2'd2;
        diff = r_in[s] - c2;
      end else if (r_in[s] >= c1) begin
        dig  = 2'd1;
        diff = r_in[s] - c1;
      end else begin
        dig  = 2'd0;
        diff = r_in[s];
      end
      rem_nxt[s] = diff[40:0];
      // The year wraps at 16 bits, so only the low block bits are kept.
      q_nxt[s]   = 14'({q_in[s], dig});
      m7_nxt[s]  = scd_pkg::mod7_step(m7_in[s], dig);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) begin
        if (en[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        m7_r[s]  <= m7_nxt[s];
      end
    end
  end

  assign in_ready              = en[0];
  assign out_valid             = v_r[N-1];
  assign out_blk.blocks_lo     = q_r[N-1];
  assign out_blk.blocks_mod7   = m7_r[N-1];
  assign out_blk.rest          = rem_r[N-1][26:0];

  `SCD_ASSERT_IMPL(a_rest_in_block, v_r[N-1], rem_r[N-1] < 41'(scd_pkg::BLOCK_SECONDS), "block remainder not below block length")
  `SCD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_r[0], "accepted word did not enter the first stage")

endmodule

@@ rtl/core/scd_day_div.sv @@
// ----------------------------------------------------------------------------
// Year and day divider
// Picks the year within the four-year block, then divides the seconds of
// the year by the day length, two quotient bits per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_day_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  scd_pkg::blk_t in_blk,
  output logic          out_valid,
  input  logic          out_ready,
  output scd_pkg::day_t out_day
);

  localparam int N = scd_pkg::DAY_STAGES;
  localparam logic [26:0] Y1 = 27'(scd_pkg::LEAP_YEAR_SECONDS);
  localparam logic [26:0] Y2 = Y1 + 27'(scd_pkg::PLAIN_YEAR_SECONDS);
  localparam logic [26:0] Y3 = Y2 + 27'(scd_pkg::PLAIN_YEAR_SECONDS);

  logic [N-1:0] v_r;
  logic [N-1:0] v_in;
  logic [N:0]   en;
  logic [24:0]  rem_nxt  [N];
  logic [8:0]   q_nxt    [N];
  logic [2:0]   m7_nxt   [N];
  logic [15:0]  year_nxt [N];
  logic [4:0]   cyc_nxt  [N];
  logic         leap_nxt [N];
  logic [24:0]  rem_r    [N];
  logic [8:0]   q_r      [N];
  logic [2:0]   m7_r     [N];
  logic [15:0]  year_r   [N];
  logic [4:0]   cyc_r    [N];
  logic         leap_r   [N];

  // Stage advance chain.
  always_comb begin
    en[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  // Stage inputs: the first stage picks the year within the block, the
  // others each produce one radix-4 digit of the day count.
  always_comb begin
    logic [1:0]  pos;
    logic [26:0] base;
    logic [26:0] ydiff;
    logic [25:0] r, c1, c2, c3, diff;
    logic [1:0]  dig;
    // First stage: year within the block by three parallel compares.
    if (in_blk.rest >= Y3) begin
      pos  = 2'd3;
      base = Y3;
    end else if (in_blk.rest >= Y2) begin
      pos  = 2'd2;
      base = Y2;
    end else if (in_blk.rest >= Y1) begin
      pos  = 2'd1;
      base = Y1;
    end else begin
      pos  = 2'd0;
      base = '0;
    end
    ydiff       = in_blk.rest - base;
    v_in[0]     = in_valid;
    rem_nxt[0]  = ydiff[24:0];
    q_nxt[0]    = '0;
    m7_nxt[0]   = '0;
    year_nxt[0] = {in_blk.blocks_lo, pos};
    // Four years per block, so year mod 28 is 4 * (blocks mod 7) + pos.
    cyc_nxt[0]  = {in_blk.blocks_mod7, 2'b00} + {3'b000, pos};
    leap_nxt[0] = (pos == 2'd0);

    // Remaining stages: one radix-4 digit of the day count each.
    for (int s = 1; s < N; s++) begin
      r  = {1'b0, rem_r[s-1]};
      c1 = 26'(scd_pkg::DAY_SECONDS) << (2 * (N - 1 - s));
      c2 = c1 << 1;
      c3 = c1 + c2;
      if (r >= c3) begin
        dig  = 2'd3;
        diff = r - c3;
      end else if (r >= c2) begin
        dig  = 2'd2;
        diff = r - c2;
      end else if (r >= c1) begin
        dig  = 2'd1;
        diff = r - c1;
      end else begin
        dig  = 2'd0;
        diff = r;
      end
      v_in[s]     = v_r[s-1];
      rem_nxt[s]  = diff[24:0];
      q_nxt[s]    = 9'({q_r[s-1], dig});
      m7_nxt[s]   = scd_pkg::mod7_step(m7_r[s-1], dig);
      year_nxt[s] = year_r[s-1];
      cyc_nxt[s]  = cyc_r[s-1];
      leap_nxt[s] = leap_r[s-1];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) begin
        if (en[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt[s];
        q_r[s]    <= q_nxt[s];
        m7_r[s]   <= m7_nxt[s];
        year_r[s] <= year_nxt[s];
        cyc_r[s]  <= cyc_nxt[s];
        leap_r[s] <= leap_nxt[s];
      end
    end
  end

  assign in_ready           = en[0];
  assign out_valid          = v_r[N-1];
  assign out_day.year       = year_r[N-1];
  assign out_day.cycle_year = cyc_r[N-1];
  assign out_day.leap       = leap_r[N-1];
  assign out_day.yday       = q_r[N-1];
  assign out_day.yday_mod7  = m7_r[N-1];
  assign out_day.sod        = rem_r[N-1][16:0];

  `SCD_ASSERT_IMPL(a_sod_in_day, v_r[N-1], rem_r[N-1] < 25'(scd_pkg::DAY_SECONDS),
                   "seconds of day not below day length")
  `SCD_ASSERT_IMPL(a_plain_year_len, v_r[N-1] && !leap_r[N-1], q_r[N-1] < 9'd365,
                   "day of plain year out of range")

endmodule

@@ rtl/core/scd_clock_split.sv @@
// ----------------------------------------------------------------------------
// Clock and calendar splitter
// Divides the seconds of the day into hour, minute and second, two quotient
// bits per stage, while month, day of month and weekday are formed alongside.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_clock_split (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  scd_pkg::day_t              in_day,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scd_pkg::YEAR_W-1:0] out_year_index,
  output logic [3:0]                 out_month_number,
  output logic [4:0]                 out_day_of_month,
  output logic [2:0]                 out_weekday,
  output logic [4:0]                 out_hour_of_day,
  output logic [5:0]                 out_minute_of_hour,
  output logic [5:0]                 out_second_of_minute
);

  localparam int N  = scd_pkg::HMS_STAGES;
  localparam int HN = N / 2;

  logic [N-1:0] v_r;
  logic [N-1:0] v_in;
  logic [N:0]   en;

  // Carried through every stage.
  logic [15:0] year_nxt  [N];
  logic [3:0]  month_nxt [N];
  logic [4:0]  dom_nxt   [N];
  logic [2:0]  wday_nxt  [N];
  logic [4:0]  hour_nxt  [N];
  logic [15:0] year_r    [N];
  logic [3:0]  month_r   [N];
  logic [4:0]  dom_r     [N];
  logic [2:0]  wday_r    [N];
  logic [4:0]  hour_r    [N];

  // Hour and minute division remainders and the minute quotient.
  logic [16:0] hrem_nxt [HN];
  logic [16:0] hrem_r   [HN];
  logic [11:0] mrem_nxt [HN];
  logic [11:0] mrem_r   [HN];
  logic [5:0]  min_nxt  [HN];
  logic [5:0]  min_r    [HN];

  // Day of year and leap flag held for the day-of-month stage.
  logic [8:0]  yday_r;
  logic        leap_r;

  // Stage advance chain.
  always_comb begin
    en[N] = out_ready;
    for (int s = N - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  // Calendar side: month index and weekday in the first stage, month number
  // and day of month in the second, then carried unchanged.
  always_comb begin
    logic [3:0] mon;
    mon = '0;
    for (int k = 1; k < 12; k++) begin
      if (in_day.yday >= scd_pkg::MONTH_START[in_day.leap][k]) begin
        mon = 4'(k);
      end
    end
    v_in[0]      = in_valid;
    year_nxt[0]  = in_day.year;
    month_nxt[0] = mon;
    dom_nxt[0]   = '0;
    wday_nxt[0]  = scd_pkg::mod7_add(scd_pkg::WEEK_OFFSET_MOD7[in_day.cycle_year],
                                     in_day.yday_mod7);
    for (int s = 1; s < N; s++) begin
      v_in[s]      = v_r[s-1];
      year_nxt[s]  = year_r[s-1];
      month_nxt[s] = month_r[s-1];
      dom_nxt[s]   = dom_r[s-1];
      wday_nxt[s]  = wday_r[s-1];
    end
    month_nxt[1] = month_r[0] + 4'd1;
    dom_nxt[1]   = 5'(yday_r - scd_pkg::MONTH_START[leap_r][month_r[0]] + 9'd1);
  end

  // Hour division: one radix-4 digit in each of the first stages.
  always_comb begin
    logic [17:0] r, c1, c2, c3, diff;
    logic [1:0]  dig;
    logic [4:0]  h;
    for (int s = 0; s < HN; s++) begin
      if (s == 0) begin
        r = {1'b0, in_day.sod};
        h = '0;
      end else begin
        r = {1'b0, hrem_r[s-1]};
        h = hour_r[s-1];
      end
      c1 = 18'(scd_pkg::HOUR_SECONDS) << (2 * (HN - 1 - s));
      c2 = c1 << 1;
      c3 = c1 + c2;
      if (r >= c3) begin
        dig  = 2'd3;
        diff = r - c3;
      end else if (r >= c2) begin
        dig  = 2'd2;
        diff = r - c2;
      end else if (r >= c1) begin
        dig  = 2'd1;
        diff = r - c1;
      end else begin
        dig  = 2'd0;
        diff = r;
      end
      hrem_nxt[s] = diff[16:0];
      // The hour stays below 24, so the top quotient bit is always zero.
      hour_nxt[s] = 5'({h, dig});
    end
    for (int s = HN; s < N; s++) begin
      hour_nxt[s] = hour_r[s-1];
    end
  end

  // Minute division on what is left of the hour; the last remainder is the
  // second of the minute.
  always_comb begin
    logic [11:0] r, c1, c2, c3, diff;
    logic [1:0]  dig;
    logic [5:0]  m;
    for (int s = 0; s < HN; s++) begin
      if (s == 0) begin
        r = hrem_r[HN-1][11:0];
        m = '0;
      end else begin
        r = mrem_r[s-1];
        m = min_r[s-1];
      end
      c1 = 12'(scd_pkg::MINUTE_SECONDS) << (2 * (HN - 1 - s));
      c2 = c1 << 1;
      c3 = c1 + c2;
      if (r >= c3) begin
        dig  = 2'd3;
        diff = r - c3;
      end else if (r >= c2) begin
        dig  = 2'd2;
        diff = r - c2;
      end else if (r >= c1) begin
        dig  = 2'd1;
        diff = r - c1;
      end else begin
        dig  = 2'd0;
        diff = r;
      end
      mrem_nxt[s] = diff;
      min_nxt[s]  = 6'({m, dig});
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < N; s++) begin
        if (en[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (en[s]) begin
        year_r[s]  <= year_nxt[s];
        month_r[s] <= month_nxt[s];
        dom_r[s]   <= dom_nxt[s];
        wday_r[s]  <= wday_nxt[s];
        hour_r[s]  <= hour_nxt[s];
      end
    end
    for (int s = 0; s < HN; s++) begin
      if (en[s]) begin
        hrem_r[s] <= hrem_nxt[s];
      end
      if (en[HN+s]) begin
        mrem_r[s] <= mrem_nxt[s];
        min_r[s]  <= min_nxt[s];
      end
    end
    if (en[0]) begin
      yday_r <= in_day.yday;
      leap_r <= in_day.leap;
    end
  end

  assign in_ready             = en[0];
  assign out_valid            = v_r[N-1];
  assign out_year_index       = year_r[N-1];
  assign out_month_number     = month_r[N-1];
  assign out_day_of_month     = dom_r[N-1];
  assign out_weekday          = wday_r[N-1];
  assign out_hour_of_day      = hour_r[N-1];
  assign out_minute_of_hour   = min_r[HN-1];
  assign out_second_of_minute = mrem_r[HN-1][5:0];

  `SCD_ASSERT_IMPL(a_clock_range, out_valid, out_hour_of_day < 5'd24 && out_minute_of_hour < 6'd60 && mrem_r[HN-1] < 12'd60, "clock field out of range")
  `SCD_ASSERT_IMPL(a_date_range, out_valid, out_month_number >= 4'd1 && out_month_number <= 4'd12 && out_day_of_month >= 5'd1 && out_weekday < 3'd7, "date field out of range")

endmodule

@@ rtl/core/seconds_to_calendar_date.sv @@
// Pipeline: 20 register stages between the input and the output.
// Throughput: one word per cycle while out_ready is high; every stage does one
// radix-4 division step or a set of parallel compares, and empty stages fill in
// during stalls.
// Reset: rst_n (synchronous, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
// Seconds to calendar date converter
// Breaks a count of seconds since the start of epoch year 0 into year, month,
// day of month, weekday, hour, minute and second.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scd_pkg::SECS_W-1:0]  in_seconds_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scd_pkg::YEAR_W-1:0]  out_year_index,
  output logic [3:0]                  out_month_number,
  output logic [4:0]                  out_day_of_month,
  output logic [2:0]                  out_weekday,
  output logic [4:0]                  out_hour_of_day,
  output logic [5:0]                  out_minute_of_hour,
  output logic [5:0]                  out_second_of_minute
);

  logic          blk_valid;
  logic          blk_ready;
  scd_pkg::blk_t blk_word;
  logic          day_valid;
  logic          day_ready;
  scd_pkg::day_t day_word;

  // Four-year block division.
  scd_block_div u_block_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_seconds (in_seconds_count),
    .out_valid  (blk_valid),
    .out_ready  (blk_ready),
    .out_blk    (blk_word)
  );

  // Year within the block and day of the year.
  scd_day_div u_day_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (blk_valid),
    .in_ready  (blk_ready),
    .in_blk    (blk_word),
    .out_valid (day_valid),
    .out_ready (day_ready),
    .out_day   (day_word)
  );

  // Time of day, month, day of month and weekday.
  scd_clock_split u_clock_split (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (day_valid),
    .in_ready             (day_ready),
    .in_day               (day_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year_index       (out_year_index),
    .out_month_number     (out_month_number),
    .out_day_of_month     (out_day_of_month),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

endmodule

@@ test/seconds_to_calendar_date_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date converter testbench
// Feeds second counts through the converter under random idling and
// backpressure. Each accepted word is broken down into a calendar date by an
// independent predictor, and every result word is compared field by field.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_tb;

  localparam int SECS_BITS = 41;

  // Interval lengths in seconds.
  localparam longint unsigned FOUR_YEAR_SECS  = 64'd126230400;
  localparam longint unsigned LEAP_YEAR_SECS  = 64'd31622400;
  localparam longint unsigned PLAIN_YEAR_SECS = 64'd31536000;
  localparam longint unsigned SECS_PER_DAY    = 64'd86400;
  localparam longint unsigned SECS_PER_HOUR   = 64'd3600;
  localparam longint unsigned SECS_PER_MIN    = 64'd60;
  localparam longint unsigned CYCLE_YEARS     = 64'd28;

  // First count whose year no longer fits in 16 bits.
  localparam longint unsigned YEAR_WRAP_SECS = 64'd2068158873600;

  localparam int FEBRUARY = 1;
  localparam int DECEMBER = 11;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam int RANDOM_WORDS   = 1500;
  localparam int IDLE_PCT       = 21;
  localparam int HOLDOFF_AT     = 300;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int QUIET_FIRST    = 300;
  localparam int QUIET_LAST     = 600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int STUCK_LIMIT    = 4000;

  typedef struct {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  // Holds the predicted dates in acceptance order and checks result words.
  class calendar_scoreboard;
    cal_date_t dates_due[$];
    int        errors;
    int        checked;

    function cal_date_t date_of(logic [SECS_BITS-1:0] secs);
      longint unsigned rest, year, yday, sod, cyc;
      int        pos;
      int        mon;
      int        mlen;
      bit        leap;
      cal_date_t d;
      rest = secs;
      year = (rest / FOUR_YEAR_SECS) * 4;
      rest = rest % FOUR_YEAR_SECS;
      // Walk through the years of the four-year block; the first one is leap.
      pos = 0;
      while (pos < 3 && rest >= ((pos == 0) ? LEAP_YEAR_SECS : PLAIN_YEAR_SECS)) begin
        rest -= (pos == 0) ? LEAP_YEAR_SECS : PLAIN_YEAR_SECS;
        pos++;
      end
      year += pos;
      leap = (pos == 0);
      yday = rest / SECS_PER_DAY;
      sod  = rest % SECS_PER_DAY;
      // Walk the months; December takes whatever is left.
      mon  = 0;
      rest = yday;
      while (mon < DECEMBER) begin
        mlen = MONTH_DAYS[mon] + ((mon == FEBRUARY && leap) ? 1 : 0);
        if (rest < mlen) begin
          break;
        end
        rest -= mlen;
        mon++;
      end
      // Each year shifts the weekday by one, plus one more after a leap year.
      cyc      = year % CYCLE_YEARS;
      d.year   = year[15:0];
      d.month  = 4'(mon + 1);
      d.mday   = 5'(rest + 1);
      d.wday   = 3'((cyc + (cyc + 3) / 4 + yday) % 7);
      d.hour   = 5'(sod / SECS_PER_HOUR);
      d.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      d.second = 6'(sod % SECS_PER_MIN);
      return d;
    endfunction

    function void note_word(logic [SECS_BITS-1:0] secs);
      dates_due.push_back(date_of(secs));
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_word(cal_date_t act);
      cal_date_t exp;
      if (dates_due.size() == 0) begin
        $display("%0t: result word with none expected, actual year %0d month %0d day %0d",
                 $time, act.year, act.month, act.mday);
        errors++;
        return;
      end
      exp = dates_due.pop_front();
      checked++;
      compare_field("year_index", exp.year, act.year);
      compare_field("month_number", exp.month, act.month);
      compare_field("day_of_month", exp.mday, act.mday);
      compare_field("weekday", exp.wday, act.wday);
      compare_field("hour_of_day", exp.hour, act.hour);
      compare_field("minute_of_hour", exp.minute, act.minute);
      compare_field("second_of_minute", exp.second, act.second);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SECS_BITS-1:0] in_seconds_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [15:0]          out_year_index;
  logic [3:0]           out_month_number;
  logic [4:0]           out_day_of_month;
  logic [2:0]           out_weekday;
  logic [4:0]           out_hour_of_day;
  logic [5:0]           out_minute_of_hour;
  logic [5:0]           out_second_of_minute;

  calendar_scoreboard sb;
  bit holdoff_req;
  bit no_idle;
  int holdoffs_done;
  int input_stalls;
  int stuck_cycles;
  int words_sent;

  seconds_to_calendar_date dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_seconds_count     (in_seconds_count),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year_index       (out_year_index),
    .out_month_number     (out_month_number),
    .out_day_of_month     (out_day_of_month),
    .out_weekday          (out_weekday),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  always #4 clk = ~clk;

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_word(input logic [SECS_BITS-1:0] secs, input bit may_idle);
    while (may_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_seconds_count <= secs;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_word(secs);
    words_sent++;
  endtask

  // Random count: anywhere in 41 bits, within the 16-bit year range, or on a
  // day, hour, minute or year edge of a random four-year block.
  function automatic logic [SECS_BITS-1:0] random_secs();
    longint unsigned t;
    int              pos;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        return {9'($urandom_range(511, 0)), 32'($urandom)};
      end
      4, 5, 6: begin
        t = {32'($urandom), 32'($urandom)};
        return SECS_BITS'(t % YEAR_WRAP_SECS);
      end
      default: begin
        pos = $urandom_range(3, 0);
        t   = longint'($urandom_range(17420, 0)) * FOUR_YEAR_SECS;
        t  += (pos == 0) ? 0 : LEAP_YEAR_SECS + (pos - 1) * PLAIN_YEAR_SECS;
        t  += longint'($urandom_range((pos == 0) ? 365 : 364, 0)) * SECS_PER_DAY;
        case ($urandom_range(3, 0))
          0: t += SECS_PER_DAY - 1;
          1: t += SECS_PER_HOUR - 1;
          2: t += SECS_PER_MIN - 1;
          default: t -= (t > 0) ? 1 : 0;
        endcase
        return SECS_BITS'(t);
      end
    endcase
  endfunction

  // Receiver: random backpressure, none in the quiet stretch, one long hold-off.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
        holdoffs_done++;
      end else begin
        out_ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word('{out_year_index, out_month_number, out_day_of_month, out_weekday,
                      out_hour_of_day, out_minute_of_hour, out_second_of_minute});
    end
  end

  // Watchdog on progress of either channel, plus a count of input stalls.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (rst_n && in_valid && !in_ready) begin
      input_stalls <= input_stalls + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [SECS_BITS-1:0] directed [$];
    sb               = new();
    stuck_cycles     = 0;
    input_stalls     = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_seconds_count <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Epoch start, clock rollovers, month and leap-day edges, year and block
    // edges, the 28-year weekday cycle, the 16-bit year wrap and bit patterns.
    directed = '{41'd0, 41'd59, 41'd60, 41'd3599, 41'd3600, 41'd86399, 41'd86400,
                 41'd2678399, 41'd2678400, 41'd5097600, 41'd5184000, 41'd31622399,
                 41'd31622400, 41'd36633600, 41'd36720000, 41'd126230399,
                 41'd126230400, 41'd883612799, 41'd883612800, 41'd2068158873599,
                 41'd2068158873600, 41'h1FF_FFFF_FFFF, 41'h0AA_AAAA_AAAA,
                 41'h155_5555_5555};
    foreach (directed[i]) begin
      send_word(directed[i], 1'b1);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= QUIET_FIRST && i < QUIET_LAST);
      if (i == HOLDOFF_AT) begin
        holdoff_req = 1'b1;
      end
      send_word(random_secs(), !no_idle);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.dates_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d directed), %0d results checked.",
             words_sent, directed.size(), sb.checked);
    $display("Input stalled %0d cycles; %0d long output hold-off(s).",
             input_stalls, holdoffs_done);
    if (sb.errors == 0 && sb.dates_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
